[sv/drpi_pkg.sv]
package drpi_pkg;

    // Default build values.
    localparam int TIME_FRAC_BITS_DEF = 20;
    localparam int CORDIC_STEPS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF    = 4;

    // Request kinds carried in the input tuser field.
    localparam logic [1:0] REQ_GPS     = 2'd0;
    localparam logic [1:0] REQ_IMU     = 2'd1;
    localparam logic [1:0] REQ_ODO     = 2'd2;
    localparam logic [1:0] REQ_RESTART = 2'd3;

    // Result sources.
    localparam logic SRC_IMU = 1'b0;
    localparam logic SRC_ODO = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_X       = 2'd0;
    localparam logic [1:0] CFG_START_Y       = 2'd1;
    localparam logic [1:0] CFG_START_HEADING = 2'd2;

    // Configuration reset values.
    localparam logic [31:0] START_X_RST       = 32'd112441426;
    localparam logic [31:0] START_Y_RST       = 32'd66488238;
    localparam logic [15:0] START_HEADING_RST = 16'd26535;

    // CORDIC gain correction, 1/K in Q30.
    localparam logic [29:0] KINV_Q30 = 30'd652032874;

    // Arctangent table depth and index width.
    localparam int ATAN_DEPTH = 24;
    localparam int ATAN_IW    = $clog2(ATAN_DEPTH);

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input logic [ATAN_IW-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // One classified request as it waits in the queue.
    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] ts;
        logic [32:0] mx;
        logic        xneg;
        logic [32:0] my;
        logic        yneg;
        logic [31:0] rate;
    } item_t;

    // Start values from the configuration registers.
    typedef struct packed {
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [15:0] start_heading;
    } cfg_t;

    // Request to the shared multiplier.
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    // One result item.
    typedef struct packed {
        logic        source;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] heading;
        logic        saturated;
    } res_t;

endpackage

[sv/drpi_front.sv]
module drpi_front
    import drpi_pkg::*;
(
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         q_full,
    output logic         q_push,
    output item_t        q_item
);

    logic [31:0] raw_x;
    logic [31:0] raw_y;

    // A request is taken whenever the queue has room.
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign raw_x = s_tdata[79:48];
    assign raw_y = s_tdata[111:80];

    // Split the body components into magnitude and sign.
    always_comb begin
        q_item.kind = s_tuser;
        q_item.ts   = s_tdata[47:0];
        q_item.rate = s_tdata[143:112];
        q_item.xneg = raw_x[31];
        q_item.yneg = raw_y[31];
        q_item.mx   = raw_x[31] ? (33'h1_0000_0000 - {1'b0, raw_x}) : {1'b0, raw_x};
        q_item.my   = raw_y[31] ? (33'h1_0000_0000 - {1'b0, raw_y}) : {1'b0, raw_y};
    end

endmodule

[sv/drpi_fifo.sv]
module drpi_fifo
    import drpi_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head_item,
    output logic  full,
    output logic  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/drpi_mul.sv]
module drpi_mul
    import drpi_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  mul_req_t     req,
    output logic         done,
    output logic [127:0] prod
);

    logic          busy_reg;
    logic          busy_next;
    logic [2:0]    cnt_reg;
    logic [2:0]    cnt_next;
    logic          done_reg;
    logic          done_next;
    logic [63:0]   a_reg;
    logic [63:0]   a_next;
    logic [63:0]   b_reg;
    logic [63:0]   b_next;
    logic [63:0]   pp_reg;
    logic [63:0]   pp_next;
    logic [1:0]    sh_reg;
    logic [1:0]    sh_next;
    logic [127:0]  acc_reg;
    logic [127:0]  acc_next;
    logic [31:0]   a_half;
    logic [31:0]   b_half;
    logic [127:0]  pp_shifted;

    assign done = done_reg;
    assign prod = acc_reg;

    // Halves chosen for the partial product of this cycle.
    assign a_half     = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half     = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp_shifted = {64'd0, pp_reg} << {sh_reg, 5'd0};

    // Four 32 by 32 partial products, each added in the cycle after it is formed.
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        pp_next   = pp_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
        end else if (busy_reg) begin
            if (cnt_reg != 3'd0) begin
                acc_next = acc_reg + pp_shifted;
            end
            if (cnt_reg == 3'd4) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                pp_next  = a_half * b_half;
                sh_next  = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        pp_reg  <= pp_next;
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
    end

endmodule

[sv/drpi_back.sv]
module drpi_back
    import drpi_pkg::*;
#(
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  logic         q_empty,
    input  item_t        q_head,
    output logic         q_pop,
    output mul_req_t     mreq,
    input  logic         mul_done,
    input  logic [127:0] mul_p,
    output logic         m_valid,
    input  logic         m_ready,
    output res_t         m_res
);

    localparam int HK = 16 + TIME_FRAC_BITS;
    localparam logic [127:0] HALF   = 128'd1 << (TIME_FRAC_BITS - 1);
    localparam logic [127:0] SQ_CAP = 128'd1 << 62;
    localparam logic [127:0] B_CAP  = 128'd1 << 33;
    localparam logic [63:0]  H_HALF = 64'd1 << (HK - 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DT      = 4'd1;
    localparam logic [3:0] S_SQ_GO   = 4'd2;
    localparam logic [3:0] S_SQ_WAIT = 4'd3;
    localparam logic [3:0] S_H_GO    = 4'd4;
    localparam logic [3:0] S_H_WAIT  = 4'd5;
    localparam logic [3:0] S_X_GO    = 4'd6;
    localparam logic [3:0] S_X_WAIT  = 4'd7;
    localparam logic [3:0] S_Y_GO    = 4'd8;
    localparam logic [3:0] S_Y_WAIT  = 4'd9;
    localparam logic [3:0] S_KX_GO   = 4'd10;
    localparam logic [3:0] S_KX_WAIT = 4'd11;
    localparam logic [3:0] S_KY_GO   = 4'd12;
    localparam logic [3:0] S_KY_WAIT = 4'd13;
    localparam logic [3:0] S_ROT     = 4'd14;
    localparam logic [3:0] S_SUM     = 4'd15;

    typedef struct packed {
        logic [31:0] imu_px;
        logic [31:0] imu_py;
        logic [15:0] imu_head;
        logic [31:0] wheel_px;
        logic [31:0] wheel_py;
        logic [15:0] wheel_head;
        logic [47:0] imu_last;
        logic [47:0] wheel_last;
        logic        fix_seen;
    } pose_t;

    typedef struct packed {
        logic [47:0]        d;
        logic               dneg;
        logic [62:0]        sq;
        logic               sqhit;
        logic               hit;
        logic [34:0]        bx;
        logic [34:0]        by;
        logic [39:0]        x;
        logic [39:0]        y;
        logic [33:0]        z;
        logic [ATAN_IW-1:0] step;
    } work_t;

    logic [3:0]   st_reg;
    logic [3:0]   st_next;
    pose_t        ps_reg;
    pose_t        ps_next;
    pose_t        ps_start;
    work_t        wk_reg;
    work_t        wk_next;
    item_t        item_reg;
    item_t        item_next;
    logic         mv_reg;
    logic         mv_next;
    res_t         res_reg;
    res_t         res_next;

    logic         is_imu;
    logic [47:0]  last_t;
    logic         ts_back;
    logic [47:0]  d_val;
    logic [63:0]  dts64;
    logic [127:0] rs;
    logic         sq_over;
    logic         b_over;
    logic [33:0]  b_mag;
    logic [33:0]  bxm;
    logic [33:0]  bym;
    logic         force_x;
    logic         force_y;
    logic         neg_x;
    logic         neg_y;
    logic [34:0]  bx_val;
    logic [34:0]  by_val;
    logic [63:0]  h_sum;
    logic [15:0]  h_inc;
    logic [63:0]  scaled64;
    logic [39:0]  scaled;
    logic [33:0]  z_init;
    logic         pre_hi;
    logic         pre_lo;
    logic [39:0]  sx;
    logic [39:0]  sy;
    logic [33:0]  atan_z;
    logic [31:0]  cur_px;
    logic [31:0]  cur_py;
    logic [39:0]  sum_x;
    logic [39:0]  sum_y;
    logic [31:0]  new_px;
    logic [31:0]  new_py;
    logic         clip_x;
    logic         clip_y;
    logic         out_free;

    assign m_valid  = mv_reg;
    assign m_res    = res_reg;
    assign out_free = !mv_reg || m_ready;

    // Pose values after a restart, from the current start registers.
    always_comb begin
        ps_start.imu_px     = cfg.start_x;
        ps_start.imu_py     = cfg.start_y;
        ps_start.imu_head   = cfg.start_heading;
        ps_start.wheel_px   = cfg.start_x;
        ps_start.wheel_py   = cfg.start_y;
        ps_start.wheel_head = cfg.start_heading;
        ps_start.imu_last   = '0;
        ps_start.wheel_last = '0;
        ps_start.fix_seen   = 1'b0;
    end

    // Time step since the last sample of the same source.
    assign is_imu  = (item_reg.kind == REQ_IMU);
    assign last_t  = is_imu ? ps_reg.imu_last : ps_reg.wheel_last;
    assign ts_back = item_reg.ts < last_t;
    assign d_val   = ts_back ? (last_t - item_reg.ts) : (item_reg.ts - last_t);
    assign dts64   = wk_reg.dneg ? (64'd0 - {16'd0, wk_reg.d}) : {16'd0, wk_reg.d};

    // Rounded shift of a product, with the caps of the square and the body step.
    assign rs      = (mul_p + HALF) >> TIME_FRAC_BITS;
    assign sq_over = rs > SQ_CAP;
    assign b_over  = rs > B_CAP;
    assign b_mag   = b_over ? B_CAP[33:0] : rs[33:0];

    // A capped square forces a nonzero component to the body limit.
    assign force_x = is_imu && wk_reg.sqhit && (item_reg.mx != '0);
    assign force_y = is_imu && wk_reg.sqhit && (item_reg.my != '0);
    assign bxm     = force_x ? B_CAP[33:0] : b_mag;
    assign bym     = force_y ? B_CAP[33:0] : b_mag;
    assign neg_x   = is_imu ? item_reg.xneg : (item_reg.xneg ^ wk_reg.dneg);
    assign neg_y   = is_imu ? item_reg.yneg : (item_reg.yneg ^ wk_reg.dneg);
    assign bx_val  = neg_x ? (35'd0 - {1'b0, bxm}) : {1'b0, bxm};
    assign by_val  = neg_y ? (35'd0 - {1'b0, bym}) : {1'b0, bym};

    // Heading increment, rounded half up.
    assign h_sum = mul_p[63:0] + H_HALF;
    assign h_inc = h_sum[HK+15:HK];

    // Gain correction with a floor shift.
    assign scaled64 = $signed(mul_p[63:0]) >>> 30;
    assign scaled   = scaled64[39:0];

    // Heading as a signed angle; fold it into the right half plane.
    assign z_init = {{2{ps_reg.imu_head[15]}}, ps_reg.imu_head, 16'd0};
    assign pre_hi = $signed(z_init) > $signed(34'h0_4000_0000);
    assign pre_lo = $signed(z_init) < $signed(34'h3_C000_0000);

    // One CORDIC iteration.
    assign sx     = $signed(wk_reg.x) >>> wk_reg.step;
    assign sy     = $signed(wk_reg.y) >>> wk_reg.step;
    assign atan_z = {2'b00, atan_turn(wk_reg.step)};

    // Position update with clipping to the 32-bit range.
    assign cur_px = is_imu ? ps_reg.imu_px : ps_reg.wheel_px;
    assign cur_py = is_imu ? ps_reg.imu_py : ps_reg.wheel_py;
    assign sum_x  = {{8{cur_px[31]}}, cur_px} + wk_reg.x;
    assign sum_y  = {{8{cur_py[31]}}, cur_py} + wk_reg.y;
    always_comb begin
        clip_x = 1'b1;
        clip_y = 1'b1;
        if ($signed(sum_x) > $signed(40'sh00_7FFF_FFFF)) begin
            new_px = 32'h7FFF_FFFF;
        end else if ($signed(sum_x) < $signed(40'shFF_8000_0000)) begin
            new_px = 32'h8000_0000;
        end else begin
            new_px = sum_x[31:0];
            clip_x = 1'b0;
        end
        if ($signed(sum_y) > $signed(40'sh00_7FFF_FFFF)) begin
            new_py = 32'h7FFF_FFFF;
        end else if ($signed(sum_y) < $signed(40'shFF_8000_0000)) begin
            new_py = 32'h8000_0000;
        end else begin
            new_py = sum_y[31:0];
            clip_y = 1'b0;
        end
    end

    // Sequencer.
    always_comb begin
        st_next   = st_reg;
        ps_next   = ps_reg;
        wk_next   = wk_reg;
        item_next = item_reg;
        mv_next   = mv_reg;
        res_next  = res_reg;
        q_pop     = 1'b0;
        mreq      = '0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (st_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop     = 1'b1;
                    item_next = q_head;
                    if (q_head.kind == REQ_RESTART) begin
                        ps_next = ps_start;
                    end else if (q_head.kind == REQ_GPS) begin
                        if (!ps_reg.fix_seen) begin
                            ps_next.imu_last   = q_head.ts;
                            ps_next.wheel_last = q_head.ts;
                            ps_next.fix_seen   = 1'b1;
                        end
                    end else begin
                        st_next = S_DT;
                    end
                end
            end
            S_DT: begin
                wk_next.d     = d_val;
                wk_next.dneg  = ts_back;
                wk_next.hit   = 1'b0;
                wk_next.sqhit = 1'b0;
                st_next       = is_imu ? S_SQ_GO : S_H_GO;
            end
            S_SQ_GO: begin
                mreq.start = 1'b1;
                mreq.a     = {16'd0, wk_reg.d};
                mreq.b     = {16'd0, wk_reg.d};
                st_next    = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (mul_done) begin
                    wk_next.sqhit = sq_over;
                    wk_next.sq    = sq_over ? SQ_CAP[62:0] : rs[62:0];
                    st_next       = S_H_GO;
                end
            end
            S_H_GO: begin
                mreq.start = 1'b1;
                mreq.a     = {{32{item_reg.rate[31]}}, item_reg.rate};
                mreq.b     = dts64;
                st_next    = S_H_WAIT;
            end
            S_H_WAIT: begin
                if (mul_done) begin
                    if (is_imu) begin
                        ps_next.imu_head = ps_reg.imu_head + h_inc;
                    end else begin
                        ps_next.wheel_head = ps_reg.wheel_head + h_inc;
                    end
                    st_next = S_X_GO;
                end
            end
            S_X_GO: begin
                mreq.start = 1'b1;
                mreq.a     = {31'd0, item_reg.mx};
                mreq.b     = is_imu ? {1'b0, wk_reg.sq} : {16'd0, wk_reg.d};
                st_next    = S_X_WAIT;
            end
            S_X_WAIT: begin
                if (mul_done) begin
                    wk_next.bx  = bx_val;
                    wk_next.hit = wk_reg.hit || b_over || force_x;
                    st_next     = S_Y_GO;
                end
            end
            S_Y_GO: begin
                mreq.start = 1'b1;
                mreq.a     = {31'd0, item_reg.my};
                mreq.b     = is_imu ? {1'b0, wk_reg.sq} : {16'd0, wk_reg.d};
                st_next    = S_Y_WAIT;
            end
            S_Y_WAIT: begin
                if (mul_done) begin
                    wk_next.by  = by_val;
                    wk_next.hit = wk_reg.hit || b_over || force_y;
                    st_next     = S_KX_GO;
                end
            end
            S_KX_GO: begin
                mreq.start = 1'b1;
                mreq.a     = {{29{wk_reg.bx[34]}}, wk_reg.bx};
                mreq.b     = {34'd0, KINV_Q30};
                st_next    = S_KX_WAIT;
            end
            S_KX_WAIT: begin
                if (mul_done) begin
                    wk_next.x = scaled;
                    st_next   = S_KY_GO;
                end
            end
            S_KY_GO: begin
                mreq.start = 1'b1;
                mreq.a     = {{29{wk_reg.by[34]}}, wk_reg.by};
                mreq.b     = {34'd0, KINV_Q30};
                st_next    = S_KY_WAIT;
            end
            S_KY_WAIT: begin
                if (mul_done) begin
                    wk_next.step = '0;
                    if (pre_hi) begin
                        wk_next.z = z_init - 34'h0_8000_0000;
                        wk_next.x = 40'd0 - wk_reg.x;
                        wk_next.y = 40'd0 - scaled;
                    end else if (pre_lo) begin
                        wk_next.z = z_init + 34'h0_8000_0000;
                        wk_next.x = 40'd0 - wk_reg.x;
                        wk_next.y = 40'd0 - scaled;
                    end else begin
                        wk_next.z = z_init;
                        wk_next.y = scaled;
                    end
                    st_next = S_ROT;
                end
            end
            S_ROT: begin
                if (!wk_reg.z[33]) begin
                    wk_next.x = wk_reg.x - sy;
                    wk_next.y = wk_reg.y + sx;
                    wk_next.z = wk_reg.z - atan_z;
                end else begin
                    wk_next.x = wk_reg.x + sy;
                    wk_next.y = wk_reg.y - sx;
                    wk_next.z = wk_reg.z + atan_z;
                end
                wk_next.step = wk_reg.step + 1'b1;
                if (wk_reg.step == ATAN_IW'(CORDIC_STEPS - 1)) begin
                    st_next = S_SUM;
                end
            end
            S_SUM: begin
                if (out_free) begin
                    if (is_imu) begin
                        ps_next.imu_px   = new_px;
                        ps_next.imu_py   = new_py;
                        ps_next.imu_last = item_reg.ts;
                    end else begin
                        ps_next.wheel_px   = new_px;
                        ps_next.wheel_py   = new_py;
                        ps_next.wheel_last = item_reg.ts;
                    end
                    res_next.source    = is_imu ? SRC_IMU : SRC_ODO;
                    res_next.pos_x     = new_px;
                    res_next.pos_y     = new_py;
                    res_next.heading   = is_imu ? ps_reg.imu_head : ps_reg.wheel_head;
                    res_next.saturated = wk_reg.hit || clip_x || clip_y;
                    mv_next            = 1'b1;
                    st_next            = S_IDLE;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    // Control and pose state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg              <= S_IDLE;
            mv_reg              <= 1'b0;
            ps_reg.imu_px       <= START_X_RST;
            ps_reg.imu_py       <= START_Y_RST;
            ps_reg.imu_head     <= START_HEADING_RST;
            ps_reg.wheel_px     <= START_X_RST;
            ps_reg.wheel_py     <= START_Y_RST;
            ps_reg.wheel_head   <= START_HEADING_RST;
            ps_reg.imu_last     <= '0;
            ps_reg.wheel_last   <= '0;
            ps_reg.fix_seen     <= 1'b0;
        end else begin
            st_reg <= st_next;
            mv_reg <= mv_next;
            ps_reg <= ps_next;
        end
    end

    // Working values and the result payload.
    always_ff @(posedge aclk) begin
        wk_reg   <= wk_next;
        item_reg <= item_next;
        res_reg  <= res_next;
    end

endmodule

[sv/dead_reckoning_pose_integrator_core.sv]
// Planar dead-reckoning pose integrator.
// Requests arrive on the s_ channel: s_tuser holds the kind (gps fix, imu
// sample, odometry sample, restart) and s_tdata the timestamp, body x and y
// and the turn rate. Every imu or odometry sample gives one result on the
// m_ channel: m_tuser is the source and m_tdata the updated pose of it.
// Gps fixes and restarts give no result.
// A front stage classifies requests into a short queue, so requests are
// taken while the back end works or while a result waits. The back end runs
// one request at a time through a shared four-pass 32 by 32 multiplier and
// an iterative CORDIC. An odometry sample takes five multiplications and an
// imu sample six; the back end takes the next request from the queue only
// once it is through with the last one. A gps fix or a restart is handled
// in the idle state of the back end as it is taken from the queue.
// The start registers are written through the cfg_ port and take effect at
// the next restart request. Reset empties the queue, drops any pending
// result and loads both poses from the register reset values.
// A stalled receiver holds the result; the back end then waits before
// writing the next one and the queue fills until s_tready falls.
module dead_reckoning_pose_integrator_core
    import drpi_pkg::*;
#(
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
)
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // timestamp[47:0], lin_x[79:48], lin_y[111:80], turn_rate[143:112]
    input  logic [143:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[31:0], pos_y[63:32], heading[79:64], saturated[80], zero fill
    output logic [87:0]  m_tdata,
    // source[0]
    output logic [0:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wr_data
);

    cfg_t         cfg_reg;
    cfg_t         cfg_next;
    logic         q_full;
    logic         q_empty;
    logic         q_push;
    logic         q_pop;
    item_t        q_in;
    item_t        q_head;
    mul_req_t     mreq;
    logic         mul_done;
    logic [127:0] mul_p;
    res_t         res;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_START_X:       cfg_next.start_x       = cfg_wr_data;
                CFG_START_Y:       cfg_next.start_y       = cfg_wr_data;
                CFG_START_HEADING: cfg_next.start_heading = cfg_wr_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_x       <= START_X_RST;
            cfg_reg.start_y       <= START_Y_RST;
            cfg_reg.start_heading <= START_HEADING_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    drpi_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    drpi_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head_item (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    drpi_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .done    (mul_done),
        .prod    (mul_p)
    );

    drpi_back #(
        .TIME_FRAC_BITS (TIME_FRAC_BITS),
        .CORDIC_STEPS   (CORDIC_STEPS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .mreq     (mreq),
        .mul_done (mul_done),
        .mul_p    (mul_p),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (res)
    );

    // Pack the result.
    assign m_tdata = {7'd0, res.saturated, res.heading, res.pos_y, res.pos_x};
    assign m_tuser = res.source;

endmodule

[sv/drpi_checker.sv]
module drpi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // Reset drops any pending result.
    a_reset_clears_result: assert property (
        @(posedge aclk) !aresetn |=> !m_tvalid
    ) else $error("result still valid after reset");

    // Reset empties the queue, so requests are taken at once.
    a_reset_opens_input: assert property (
        @(posedge aclk) !aresetn |=> s_tready
    ) else $error("input not ready after reset");

    // A stalled result holds its value.
    a_stall_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
    ) else $error("stalled result changed");

    // The fill above the saturation flag is always zero.
    a_result_fill_zero: assert property (
        @(posedge aclk) m_tdata[87:81] == 7'd0
    ) else $error("result fill bits not zero");

endmodule

bind dead_reckoning_pose_integrator_core drpi_checker u_drpi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[verif/tb_dead_reckoning_pose_integrator_core.sv]
module tb_dead_reckoning_pose_integrator_core;
    import drpi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TFB        = 20;
    localparam int STEPS      = 16;
    localparam int IDLE_LIMIT = 20000;

    // One input request as the sender holds it.
    typedef struct {
        logic [1:0]  kind;
        logic [47:0] ts;
        logic [31:0] lin_x;
        logic [31:0] lin_y;
        logic [31:0] rate;
    } pose_req_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [87:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_addr = '0;
    logic [31:0]  cfg_wr_data = '0;

    dead_reckoning_pose_integrator_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Arctangent of 2^-i in 2^-32 turn units, for the pose rotation.
    localparam longint ATAN_STEP [16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    // Predicted block state and its copy of the start registers.
    logic [31:0] start_x_q, start_y_q;
    logic [15:0] start_head_q;
    longint      imu_x, imu_y, odo_x, odo_y;
    logic [15:0] imu_hd, odo_hd;
    logic [47:0] imu_t, odo_t;
    logic        fix_done;

    pose_req_t pending_reqs[$];
    res_t      expected_poses[$];
    int        mismatches = 0;
    logic [47:0] now_ts = '0;

    function automatic void reload_poses();
        imu_x    = longint'($signed(start_x_q));
        odo_x    = imu_x;
        imu_y    = longint'($signed(start_y_q));
        odo_y    = imu_y;
        imu_hd   = start_head_q;
        odo_hd   = start_head_q;
        imu_t    = '0;
        odo_t    = '0;
        fix_done = 1'b0;
    endfunction

    // Rounded a*b/2^TFB, clipped at cap; bit 64 flags the clip.
    function automatic logic [64:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                   input logic [63:0] cap);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, a} * {64'd0, b} + (128'd1 << (TFB - 1));
        q = p >> TFB;
        if (q[127:64] != 0 || q[63:0] > cap) return {1'b1, cap};
        return {1'b0, q[63:0]};
    endfunction

    function automatic logic [15:0] turned(input logic [15:0] h, input logic [31:0] rate,
                                           input logic [63:0] dts);
        logic [63:0] p;
        p = {{32{rate[31]}}, rate} * dts + (64'd1 << (16 + TFB - 1));
        return h + p[16+TFB+15:16+TFB];
    endfunction

    // CORDIC rotation of the body displacement by a heading.
    function automatic void rotate_body(input longint bx, input longint by,
                                        input logic [15:0] h, output longint rx,
                                        output longint ry);
        longint x, y, z, t;
        x = (bx * longint'(KINV_Q30)) >>> 30;
        y = (by * longint'(KINV_Q30)) >>> 30;
        z = longint'($signed({h, 16'd0}));
        if (z > (64'sd1 <<< 30)) begin
            z = z - (64'sd1 <<< 31);
            x = -x;
            y = -y;
        end else if (z < -(64'sd1 <<< 30)) begin
            z = z + (64'sd1 <<< 31);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                x = t;
                z = z - ATAN_STEP[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                x = t;
                z = z + ATAN_STEP[i];
            end
        end
        rx = x;
        ry = y;
    endfunction

    function automatic longint clip32(input longint p, inout logic hit);
        if (p > 64'sd2147483647) begin
            hit = 1'b1;
            return 64'sd2147483647;
        end
        if (p < -64'sd2147483648) begin
            hit = 1'b1;
            return -64'sd2147483648;
        end
        return p;
    endfunction

    // Advances the predicted poses by one request; queues the pose it yields.
    function automatic void integrate_pose(input pose_req_t r);
        logic        is_imu, dneg, xneg, yneg, hit, sqhit;
        logic [47:0] last;
        logic [63:0] d, dts, mx, my, bxm, bym, sq;
        logic [64:0] pr;
        longint      bx, by, rx, ry;
        logic [15:0] hd;
        res_t        res;
        hit = 1'b0;
        if (r.kind == REQ_RESTART) begin
            reload_poses();
            return;
        end
        if (r.kind == REQ_GPS) begin
            if (!fix_done) begin
                imu_t    = r.ts;
                odo_t    = r.ts;
                fix_done = 1'b1;
            end
            return;
        end
        is_imu = (r.kind == REQ_IMU);
        last   = is_imu ? imu_t : odo_t;
        dneg   = r.ts < last;
        d      = dneg ? {16'd0, last - r.ts} : {16'd0, r.ts - last};
        dts    = dneg ? -d : d;
        xneg   = r.lin_x[31];
        yneg   = r.lin_y[31];
        mx     = xneg ? (64'd1 << 32) - r.lin_x : {32'd0, r.lin_x};
        my     = yneg ? (64'd1 << 32) - r.lin_y : {32'd0, r.lin_y};
        if (is_imu) begin
            pr     = scaled_product(d, d, 64'd1 << 62);
            sqhit  = pr[64];
            sq     = pr[63:0];
            imu_hd = turned(imu_hd, r.rate, dts);
            pr     = scaled_product(mx, sq, 64'd1 << 33);
            bxm    = pr[63:0];
            hit    = pr[64];
            pr     = scaled_product(my, sq, 64'd1 << 33);
            bym    = pr[63:0];
            hit    = hit | pr[64];
            if (sqhit && mx != 0) begin
                bxm = 64'd1 << 33;
                hit = 1'b1;
            end
            if (sqhit && my != 0) begin
                bym = 64'd1 << 33;
                hit = 1'b1;
            end
        end else begin
            odo_hd = turned(odo_hd, r.rate, dts);
            pr     = scaled_product(mx, d, 64'd1 << 33);
            bxm    = pr[63:0];
            hit    = pr[64];
            pr     = scaled_product(my, d, 64'd1 << 33);
            bym    = pr[63:0];
            hit    = hit | pr[64];
            xneg   = xneg ^ dneg;
            yneg   = yneg ^ dneg;
        end
        bx = xneg ? -longint'(bxm) : longint'(bxm);
        by = yneg ? -longint'(bym) : longint'(bym);
        rotate_body(bx, by, imu_hd, rx, ry);
        if (is_imu) begin
            imu_x = clip32(imu_x + rx, hit);
            imu_y = clip32(imu_y + ry, hit);
            imu_t = r.ts;
            res.pos_x = imu_x[31:0];
            res.pos_y = imu_y[31:0];
            hd = imu_hd;
        end else begin
            odo_x = clip32(odo_x + rx, hit);
            odo_y = clip32(odo_y + ry, hit);
            odo_t = r.ts;
            res.pos_x = odo_x[31:0];
            res.pos_y = odo_y[31:0];
            hd = odo_hd;
        end
        res.source    = is_imu ? SRC_IMU : SRC_ODO;
        res.heading   = hd;
        res.saturated = hit;
        expected_poses.push_back(res);
    endfunction

    // Sender: requests go out in bursts with random gaps between them.
    logic req_taken = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    pose_req_t cur_req;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            integrate_pose(cur_req);
            req_taken = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || req_taken)) begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                cur_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur_req.kind;
                s_tdata  <= {cur_req.rate, cur_req.lin_y, cur_req.lin_x, cur_req.ts};
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 70);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern switches at random among four modes.
    int rx_mode = 0;
    int rx_left = 0;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(10, 120);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= $urandom_range(0, 1);
            end
            2: begin
                m_tready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                m_tready <= (rx_left % 40) < 30;
            end
        endcase
    end

    // Result checker.
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected pose: source %0d data %h", m_tuser, m_tdata);
            end else begin
                want = expected_poses.pop_front();
                if (m_tuser[0] !== want.source || m_tdata[31:0] !== want.pos_x ||
                    m_tdata[63:32] !== want.pos_y || m_tdata[79:64] !== want.heading ||
                    m_tdata[80] !== want.saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Pose mismatch: exp src %0d x %h y %h hd %h sat %0d, got src %0d x %h y %h hd %h sat %0d",
                                 want.source, want.pos_x, want.pos_y, want.heading,
                                 want.saturated, m_tuser[0], m_tdata[31:0], m_tdata[63:32],
                                 m_tdata[79:64], m_tdata[80]);
                end
            end
        end
    end

    // Watchdog on cycles with no request moving on either side.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic void push_req(input logic [1:0] kind, input logic [47:0] ts,
                                     input logic [31:0] lx, input logic [31:0] ly,
                                     input logic [31:0] rate);
        pose_req_t r;
        r.kind  = kind;
        r.ts    = ts;
        r.lin_x = lx;
        r.lin_y = ly;
        r.rate  = rate;
        pending_reqs.push_back(r);
    endfunction

    // Mostly small, sometimes full-range body values.
    function automatic logic [31:0] body_value();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return 32'($signed($urandom_range(0, 40 * 65536)) - 20 * 65536);
    endfunction

    // Random tracks: samples, mostly forward in time, with restarts, fixes and noise.
    function automatic void random_track(input int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                push_req(REQ_RESTART, {$urandom, $urandom}, $urandom, $urandom, $urandom);
                push_req(REQ_GPS, now_ts, $urandom, $urandom, $urandom);
            end else if (pick < 5) begin
                push_req(2'($urandom), {$urandom, $urandom}, $urandom, $urandom, $urandom);
            end else if (pick < 8) begin
                push_req(REQ_GPS, now_ts, body_value(), body_value(), $urandom);
            end else begin
                if ($urandom_range(0, 19) == 0)
                    now_ts = now_ts - $urandom_range(1, 20000);
                else
                    now_ts = now_ts + $urandom_range(100, 60000);
                push_req($urandom_range(0, 1) ? REQ_IMU : REQ_ODO, now_ts, body_value(),
                         body_value(), $urandom_range(0, 1) ? $urandom :
                         32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)));
            end
        end
    endfunction

    task automatic write_reg(input logic [1:0] addr, input logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            CFG_START_X:       start_x_q = value;
            CFG_START_Y:       start_y_q = value;
            CFG_START_HEADING: start_head_q = value[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_poses.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] set_x [4];
        logic [31:0] set_y [4];
        logic [15:0] set_h [4];
        start_x_q    = START_X_RST;
        start_y_q    = START_Y_RST;
        start_head_q = START_HEADING_RST;
        reload_poses();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed requests under the reset start values.
        push_req(REQ_IMU, 48'd1000, 32'h00010000, 32'h0, 32'h0);
        push_req(REQ_ODO, 48'd5000, 32'h00020000, 32'hFFFF0000, 32'h00010000);
        push_req(REQ_GPS, 48'd100000, 32'h0, 32'h0, 32'h0);
        push_req(REQ_GPS, 48'd50, 32'h0, 32'h0, 32'h0);
        push_req(REQ_IMU, 48'd110000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        push_req(REQ_ODO, 48'd120000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        push_req(REQ_IMU, 48'd105000, 32'hFFFD0000, 32'h00030000, 32'hFFFF0000);
        push_req(REQ_ODO, 48'd90000, 32'h00050000, 32'h0, 32'h00400000);
        push_req(REQ_IMU, 48'hFFFFFFFFFFFF, 32'h1, 32'h0, 32'h1);
        push_req(REQ_ODO, 48'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
        push_req(REQ_IMU, 48'hFFFFFFFFFFFF, 32'h0, 32'h0, 32'h0);
        push_req(REQ_RESTART, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        push_req(REQ_GPS, 48'h0, 32'h0, 32'h0, 32'h0);
        push_req(REQ_IMU, 48'h0, 32'h0, 32'h0, 32'h0);
        push_req(REQ_ODO, 48'h100000, 32'h00010000, 32'h0, 32'h00010000);
        push_req(REQ_IMU, 48'h100000, 32'h00010000, 32'h00010000, 32'h00004000);
        now_ts = 48'h100000;
        random_track(400);
        drain();

        // Further phases at other start values, extremes among them.
        set_x = '{32'h7FFFFFFF, 32'h80000000, $urandom, 32'h0};
        set_y = '{32'h80000000, 32'h7FFFFFFF, $urandom, 32'h0};
        set_h = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h8000};
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_START_X, set_x[p]);
            write_reg(CFG_START_Y, set_y[p]);
            write_reg(CFG_START_HEADING, set_h[p]);
            push_req(REQ_RESTART, '0, '0, '0, '0);
            push_req(REQ_GPS, now_ts, '0, '0, '0);
            random_track(400);
            drain();
        end

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
